>>> design/fsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_pkg: shared types and constants of the fast sine/cosine core
// Field widths, fixed-point constants of the cubic and the function selector.
// ----------------------------------------------------------------------------
package fsc_pkg;

  // Default values of the top-level parameters.
  localparam int PHASE_BITS_DEF    = 16;
  localparam int OUT_FRAC_BITS_DEF = 14;

  // Field widths on the channels.
  localparam int ANGLE_W = 16;
  localparam int VALUE_W = 16;

  // Working format: Q0.30 magnitudes that reach 1.0, so 31 bits.
  localparam int WORK_FRAC = 30;
  localparam int TN_W      = WORK_FRAC + 1;
  localparam int PROD_W    = 2 * TN_W;

  // 1.0, c = 2 - pi/2 and 1 + c, all in Q0.30.
  localparam logic [TN_W-1:0] ONE_Q30 = TN_W'(64'd1073741824);
  localparam logic [TN_W-1:0] C3_Q30  = TN_W'(64'd460853935);
  localparam logic [TN_W-1:0] K1_Q30  = TN_W'(64'd1534595759);

  // Function selector.
  typedef enum logic {
    KIND_COS = 1'b0,
    KIND_SIN = 1'b1
  } kind_t;

endpackage

>>> design/fsc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_in_if: angle input channel
// Valid/ready channel carrying the function selector and the phase angle.
// ----------------------------------------------------------------------------
interface fsc_in_if;
  logic                             valid;
  logic                             ready;
  fsc_pkg::kind_t                   kind;
  logic [fsc_pkg::ANGLE_W-1:0]      angle_phase;

  modport source (output valid, output kind, output angle_phase, input ready);
  modport sink   (input valid, input kind, input angle_phase, output ready);
endinterface

>>> design/fsc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_out_if: result output channel
// Valid/ready channel carrying the signed sine or cosine value.
// ----------------------------------------------------------------------------
interface fsc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [fsc_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

>>> design/fast_sine_cosine_approx_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fast_sine_cosine_approx_core: pipelined cubic sine/cosine approximation
// Folds a phase angle into the first quadrant, evaluates the cubic
// f(t) = 1 - (1 + c) t^2 + c t^3 in Q0.30 and returns a signed result.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake        Payload
//  in_chan   input      valid / ready    kind (cos/sin), angle_phase[15:0]
//  out_chan  output     valid / ready    value[15:0], signed, 1.0 = 2^OUT_FRAC_BITS
//
// Throughput is one transfer per cycle on each side while out_chan is not
// stalled. An accepted angle passes through all five register stages before
// its result is presented on out_chan. The stages are fold, square, cube and
// first product, second product, sum/round/sign. The depth is set by the three
// dependent multiplications, each followed by a register.
// Reset (rst_n low, synchronous) clears every stage valid bit; data registers
// are not reset. When out_chan stalls, each stage holds only while the stage
// after it is full and held, so bubbles close up and in_chan.ready drops only
// when all five stages carry data.
// ----------------------------------------------------------------------------
module fast_sine_cosine_approx_core #(
  parameter int PHASE_BITS    = fsc_pkg::PHASE_BITS_DEF,
  parameter int OUT_FRAC_BITS = fsc_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  fsc_in_if.sink     in_chan,
  fsc_out_if.source  out_chan
);

  localparam int TN_W   = fsc_pkg::TN_W;
  localparam int PROD_W = fsc_pkg::PROD_W;
  localparam int WFRAC  = fsc_pkg::WORK_FRAC;
  localparam int VAL_W  = fsc_pkg::VALUE_W;

  // The folded angle t has PHASE_BITS-1 bits; shifting it up gives Q0.30.
  localparam int T_W     = PHASE_BITS - 1;
  localparam int SHIFT_T = 32 - PHASE_BITS;
  // Rounding from Q0.30 down to the output fraction.
  localparam int RND_SH  = WFRAC - OUT_FRAC_BITS;
  localparam logic [31:0] HALF_LSB = (32'd1 << RND_SH) >> 1;
  localparam logic [31:0] MAG_MAX  = 32'd1 << OUT_FRAC_BITS;
  localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);

  // --------------------------------------------------------------------------
  // Stage enables. A stage loads when it is empty or when the next one loads,
  // so data moves on in every cycle the output is not blocked.
  // --------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic s1_en, s2_en, s3_en, s4_en, out_en;

  assign out_en = !out_v_r || out_chan.ready;
  assign s4_en  = !s4_v_r  || out_en;
  assign s3_en  = !s3_v_r  || s4_en;
  assign s2_en  = !s2_v_r  || s3_en;
  assign s1_en  = !s1_v_r  || s2_en;

  assign in_chan.ready = s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_en)  s1_v_r  <= in_chan.valid;
      if (s2_en)  s2_v_r  <= s1_v_r;
      if (s3_en)  s3_v_r  <= s2_v_r;
      if (s4_en)  s4_v_r  <= s3_v_r;
      if (out_en) out_v_r <= s4_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: phase folding. Sine is the cosine a quarter turn earlier; the
  // subtraction wraps modulo one turn. Odd quadrants mirror the angle so that
  // t runs from 1 down to 0, and the middle two quadrants flip the sign.
  // --------------------------------------------------------------------------
  logic [PHASE_BITS-1:0] phase_w;
  logic [1:0]            quad;
  logic [T_W-1:0]        r_ext;
  logic [T_W-1:0]        t_fold;
  logic [TN_W-1:0]       s1_tn_nxt;
  logic                  s1_neg_nxt;
  logic [TN_W-1:0]       s1_tn_r;
  logic                  s1_neg_r;

  always_comb begin
    phase_w = PHASE_BITS'(in_chan.angle_phase);
    if (in_chan.kind == fsc_pkg::KIND_SIN) begin
      phase_w = phase_w - QUARTER;
    end
    quad       = phase_w[PHASE_BITS-1 -: 2];
    r_ext      = {1'b0, phase_w[PHASE_BITS-3:0]};
    t_fold     = quad[0] ? (QUARTER[T_W-1:0] - r_ext) : r_ext;
    s1_neg_nxt = quad[1] ^ quad[0];
    s1_tn_nxt  = TN_W'(t_fold) << SHIFT_T;
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_tn_r  <= s1_tn_nxt;
      s1_neg_r <= s1_neg_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: t^2, truncated back to Q0.30.
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0] sq_prod;
  logic [TN_W-1:0]   s2_t2_nxt;
  logic [TN_W-1:0]   s2_t2_r;
  logic [TN_W-1:0]   s2_tn_r;
  logic              s2_neg_r;

  assign sq_prod   = PROD_W'(s1_tn_r) * PROD_W'(s1_tn_r);
  assign s2_t2_nxt = TN_W'(sq_prod >> WFRAC);

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_t2_r  <= s2_t2_nxt;
      s2_tn_r  <= s1_tn_r;
      s2_neg_r <= s1_neg_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: t^3 and the quadratic term (1 + c) t^2, side by side.
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0] cube_prod;
  logic [PROD_W-1:0] quad_prod;
  logic [TN_W-1:0]   s3_t3_nxt;
  logic [TN_W-1:0]   s3_a_nxt;
  logic [TN_W-1:0]   s3_t3_r;
  logic [TN_W-1:0]   s3_a_r;
  logic              s3_neg_r;

  assign cube_prod = PROD_W'(s2_t2_r) * PROD_W'(s2_tn_r);
  assign quad_prod = PROD_W'(fsc_pkg::K1_Q30) * PROD_W'(s2_t2_r);
  assign s3_t3_nxt = TN_W'(cube_prod >> WFRAC);
  assign s3_a_nxt  = TN_W'(quad_prod >> WFRAC);

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_t3_r  <= s3_t3_nxt;
      s3_a_r   <= s3_a_nxt;
      s3_neg_r <= s2_neg_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: the cubic term c t^3.
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0] cterm_prod;
  logic [TN_W-1:0]   s4_b_nxt;
  logic [TN_W-1:0]   s4_b_r;
  logic [TN_W-1:0]   s4_a_r;
  logic              s4_neg_r;

  assign cterm_prod = PROD_W'(fsc_pkg::C3_Q30) * PROD_W'(s3_t3_r);
  assign s4_b_nxt   = TN_W'(cterm_prod >> WFRAC);

  always_ff @(posedge clk) begin
    if (s4_en) begin
      s4_b_r   <= s4_b_nxt;
      s4_a_r   <= s3_a_r;
      s4_neg_r <= s3_neg_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: 1 + c t^3 - (1 + c) t^2, clamped to [0, 1.0], rounded half up on
  // the magnitude, capped at 1.0 and given the quadrant sign. The result keeps
  // the low VALUE_W bits of the two's complement value.
  // --------------------------------------------------------------------------
  logic signed [TN_W+1:0] poly_sum;
  logic [TN_W-1:0]        poly_clamp;
  logic [31:0]            mag_rnd;
  logic [31:0]            mag_cap;
  logic [31:0]            val_full;
  logic [VAL_W-1:0]       out_value_nxt;
  logic [VAL_W-1:0]       out_value_r;

  always_comb begin
    poly_sum = $signed({2'b00, fsc_pkg::ONE_Q30}) + $signed({2'b00, s4_b_r})
             - $signed({2'b00, s4_a_r});
    if (poly_sum < 0) begin
      poly_clamp = '0;
    end else if (poly_sum > $signed({2'b00, fsc_pkg::ONE_Q30})) begin
      poly_clamp = fsc_pkg::ONE_Q30;
    end else begin
      poly_clamp = poly_sum[TN_W-1:0];
    end
    mag_rnd       = (32'(poly_clamp) + HALF_LSB) >> RND_SH;
    mag_cap       = (mag_rnd > MAG_MAX) ? MAG_MAX : mag_rnd;
    val_full      = s4_neg_r ? (32'd0 - mag_cap) : mag_cap;
    out_value_nxt = val_full[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_value_r <= out_value_nxt;
    end
  end

  assign out_chan.valid = out_v_r;
  assign out_chan.value = $signed(out_value_r);

endmodule

>>> design/fsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_checker: port-level checks of the fast sine/cosine core
// Watches the channel handshakes, the result range and the pipeline latency.
// ----------------------------------------------------------------------------
module fsc_checker #(
  parameter int OUT_FRAC_BITS = fsc_pkg::OUT_FRAC_BITS_DEF
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [fsc_pkg::VALUE_W-1:0] out_value
);

  localparam int MAG_MAX  = 1 << OUT_FRAC_BITS;
  localparam int FIT_FRAC = fsc_pkg::VALUE_W - 2;

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // A result that waits keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("result changed while stalled");

  // The magnitude never exceeds 1.0 where the format holds it.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (OUT_FRAC_BITS > FIT_FRAC) ||
                  ($signed(out_value) <= MAG_MAX && $signed(out_value) >= -MAG_MAX))
    else $error("result outside plus or minus one");

  // The pipeline takes a new angle whenever the output is not blocked.
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input not ready while output drains");

  // With the output draining, an accepted angle's result must be valid on the output once it has passed every stage.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind fast_sine_cosine_approx_core fsc_checker #(
  .OUT_FRAC_BITS(OUT_FRAC_BITS)
) u_fsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_value (out_chan.value)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for fast_sine_cosine_approx_core
// Streams cosine and sine requests through the core under random valid and
// ready idling, predicts each value with a bit-exact cubic model and compares
// every result transfer in order.
// ----------------------------------------------------------------------------
module testbench;
  import fsc_pkg::*;

  // One angle request as it travels on the input channel.
  typedef struct packed {
    kind_t              kind;
    logic [ANGLE_W-1:0] phase;
  } angle_req_t;

  // A request together with the value the core must return for it.
  typedef struct packed {
    angle_req_t                req;
    logic signed [VALUE_W-1:0] value;
  } trig_result_t;

  localparam int QUARTER_TURN = 1 << (ANGLE_W - 2);
  localparam int ROUND_SHIFT  = WORK_FRAC - OUT_FRAC_BITS_DEF;
  localparam int RANDOM_ANGLES = 1900;
  // Once fewer requests than this are left, both sides run without idling.
  localparam int TAIL_ANGLES  = 150;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 100;

  logic clk = 1'b0;
  logic rst_n;

  fsc_in_if  in_chan ();
  fsc_out_if out_chan ();

  fast_sine_cosine_approx_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  angle_req_t   pending_angles[$];
  trig_result_t awaited_values[$];
  int           error_count = 0;
  logic         in_tail = 1'b0;

  // Idle bookkeeping for the sender (gap) and the receiver (stall). A quiet
  // counter gives stretches where that side never idles.
  int send_gap   = 0;
  int send_quiet = 0;
  int recv_stall = 0;
  int recv_quiet = 0;

  // Bit-exact prediction of the core. The phase is folded into the first
  // quadrant as t in Q0.30, the cubic 1 - (1 + c) t^2 + c t^3 is evaluated
  // with truncating products, clamped, rounded half up to Q2.14 and signed.
  function automatic logic signed [VALUE_W-1:0] cubic_sincos(
      kind_t kind, logic [ANGLE_W-1:0] phase);
    logic [ANGLE_W-1:0]    turn;
    logic [1:0]            quad;
    logic [ANGLE_W-3:0]    rem;
    longint unsigned       t, tn, t2, t3, a, b;
    longint                y, mag;
    bit                    neg;
    turn = phase;
    // Sine is the cosine a quarter turn earlier; the subtraction wraps.
    if (kind == KIND_SIN) begin
      turn = phase - ANGLE_W'(QUARTER_TURN);
    end
    quad = turn[ANGLE_W-1 -: 2];
    rem  = turn[ANGLE_W-3:0];
    // Second and fourth quadrants are mirrored, so their boundary gives t = 1.
    t    = quad[0] ? (64'(QUARTER_TURN) - 64'(rem)) : 64'(rem);
    neg  = (quad == 2'd1) || (quad == 2'd2);
    tn   = t << (32 - ANGLE_W);
    t2   = (tn * tn) >> WORK_FRAC;
    t3   = (t2 * tn) >> WORK_FRAC;
    a    = (64'(K1_Q30) * t2) >> WORK_FRAC;
    b    = (64'(C3_Q30) * t3) >> WORK_FRAC;
    y    = longint'(64'(ONE_Q30)) + longint'(b) - longint'(a);
    if (y < 0) begin
      y = 0;
    end
    if (y > longint'(64'(ONE_Q30))) begin
      y = longint'(64'(ONE_Q30));
    end
    mag = (y + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    if (mag > (longint'(1) << OUT_FRAC_BITS_DEF)) begin
      mag = longint'(1) << OUT_FRAC_BITS_DEF;
    end
    return neg ? VALUE_W'(-mag) : VALUE_W'(mag);
  endfunction

  // Random angle: mostly uniform, a share right around the quadrant
  // boundaries, and a few at the very ends of the phase range.
  function automatic angle_req_t random_angle();
    angle_req_t req;
    int         pick;
    req.kind = kind_t'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      req.phase = ANGLE_W'($urandom_range(0, (1 << ANGLE_W) - 1));
    end else if (pick < 88) begin
      req.phase = ANGLE_W'($urandom_range(0, 3) * QUARTER_TURN + $urandom_range(0, 8) - 4);
    end else begin
      req.phase = $urandom_range(0, 1) ? ANGLE_W'($urandom_range(0, 3))
                                       : ~ANGLE_W'($urandom_range(0, 3));
    end
    return req;
  endfunction

  // Input driver. The request on the bus is booked as awaited when its
  // transfer happens; a held request stays untouched while ready is low.
  always @(posedge clk) begin
    angle_req_t next_req;
    logic       offer;
    offer    = 1'b0;
    next_req = '0;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      in_tail <= (pending_angles.size() < TAIL_ANGLES);
      if (in_chan.valid && in_chan.ready) begin
        awaited_values.push_back('{req: '{kind: in_chan.kind, phase: in_chan.angle_phase},
                                   value: cubic_sincos(in_chan.kind, in_chan.angle_phase)});
      end
      if (!(in_chan.valid && !in_chan.ready)) begin
        if (send_quiet > 0) begin
          send_quiet--;
        end else if (!in_tail && $urandom_range(0, 59) == 0) begin
          send_quiet = $urandom_range(20, 150);
        end
        if (send_gap > 0) begin
          send_gap--;
        end else if (!in_tail && send_quiet == 0 && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 18) - 1;
        end else if (pending_angles.size() > 0) begin
          next_req = pending_angles.pop_front();
          offer    = 1'b1;
        end
        // Idle cycles carry random junk on the payload, which must be ignored.
        if (!offer) begin
          next_req = angle_req_t'($urandom);
        end
        in_chan.valid       <= offer;
        in_chan.kind        <= next_req.kind;
        in_chan.angle_phase <= next_req.phase;
      end
    end
  end

  // Output monitor and ready generator. Each result transfer is checked
  // against the oldest awaited value.
  always @(posedge clk) begin
    trig_result_t oldest;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (awaited_values.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: unexpected result transfer, expected none, actual value %0d",
                     $time, out_chan.value);
          end
        end else begin
          oldest = awaited_values.pop_front();
          if (out_chan.value !== oldest.value) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("%0t: value mismatch for %s phase 0x%04h: expected %0d, actual %0d",
                       $time, oldest.req.kind.name(), oldest.req.phase,
                       oldest.value, out_chan.value);
            end
          end
        end
      end
      if (recv_quiet > 0) begin
        recv_quiet--;
      end else if (!in_tail && $urandom_range(0, 59) == 0) begin
        recv_quiet = $urandom_range(20, 150);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_chan.ready <= 1'b0;
      end else if (!in_tail && recv_quiet == 0 && $urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(1, 18) - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run. The channel signals are driven only by the
  // clocked driver and monitor, which hold them idle while reset is low.
  initial begin
    logic [ANGLE_W-1:0] corner_phases[11];
    rst_n = 1'b0;

    // Directed part: zero phase, the exact quadrant boundaries (value zero at
    // a quarter and three quarters, minus one at half a turn), their
    // neighbors, an eighth of a turn, the top of the range and the sine wrap below zero phase.
    corner_phases = '{16'h0000, 16'h0001, 16'h2000, 16'h3FFF, 16'h4000, 16'h4001,
                      16'h7FFF, 16'h8000, 16'hBFFF, 16'hC000, 16'hFFFF};
    foreach (corner_phases[i]) begin
      pending_angles.push_back('{kind: KIND_COS, phase: corner_phases[i]});
      pending_angles.push_back('{kind: KIND_SIN, phase: corner_phases[i]});
    end
    repeat (RANDOM_ANGLES) begin
      pending_angles.push_back(random_angle());
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Checked on falling edges so the clocked blocks have settled.
    do @(negedge clk); while (pending_angles.size() != 0 || in_chan.valid);
    while (awaited_values.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
